@@ src/nfba_pkg.sv @@
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and codes for the next-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfba_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] STATUS_FREE_BAD   = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] request_bytes;
    logic [3:0]  free_block;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] segment_block;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEED,
    ST_SCAN_START,
    ST_SCAN,
    ST_WRITE_REST,
    ST_MERGE_START,
    ST_MERGE,
    ST_MERGE_END,
    ST_FREE_CHECK
  } state_t;

endpackage : nfba_pkg

`default_nettype wire

@@ src/next_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit heap block allocator with coalescing of adjacent free runs.
// ----------------------------------------------------------------------------
// A zero-size, oversize or out-of-range request is answered straight from idle;
// a free reads its map entry and then checks it; an allocate scans entries from
// the next-fit pointer and, after a hit, writes any split remainder.
// A failed scan with coalescing on adds a merge pass over the map and a rescan.
// One word in flight, receiver never stalls.
// Reset (sync, active low): map is one free run, scan pointer 0, coalesce on.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_block_allocator
  import nfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 16,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // command channel
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_data,
  // result channel
  output logic           out_valid,
  output out_word_t      out_data,
  // configuration
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int MAP_W      = CNT_W + 1;   // signed map entry
  localparam int HEAP_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int HB_W       = $clog2(HEAP_BYTES + 1);
  localparam int CHK_W      = (HB_W > 17) ? HB_W : 17;

  // wrap-around increment of a block index
  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(NUM_BLOCKS - 1)) ? '0 : IDX_W'(i + IDX_W'(1));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic             coalesce_r;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;         // next-fit scan pointer
  logic [IDX_W-1:0] eval_r, eval_nxt;       // index whose map data is at rdata
  logic [IDX_W-1:0] rdaddr_r, rdaddr_nxt;   // next read address (read-ahead)
  logic [CNT_W-1:0] cnt_r, cnt_nxt;         // entries checked this scan
  logic             retry_r, retry_nxt;     // second scan after merge
  logic [CNT_W-1:0] rest_r, rest_nxt;       // split remainder length
  logic [IDX_W-1:0] rest_addr_r, rest_addr_nxt;
  logic             group_r, group_nxt;     // merge: inside a free group
  logic [IDX_W-1:0] head_r, head_nxt;       // merge: group head index
  logic [CNT_W-1:0] total_r, total_nxt;     // merge: group length so far
  logic [CNT_W-1:0] skip_r, skip_nxt;       // merge: interior blocks left
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  // map port
  logic             map_we, map_re;
  logic [IDX_W-1:0] map_waddr, map_raddr;
  logic [MAP_W-1:0] map_wdata, map_rdata;

  // rounding unit
  logic             need_load;
  logic [CNT_W-1:0] need;

  // decoded fields
  logic [IDX_W+3:0] fb_wide;
  logic [IDX_W-1:0] fb_idx;
  logic             fb_ok;
  logic [CHK_W-1:0] bytes_ext;
  logic             size_bad;
  logic             accept;
  logic             e_pos, e_neg;
  logic [CNT_W-1:0] e_mag;
  logic             fits;
  logic [CNT_W-1:0] rest;
  logic [IDX_W:0]   end_sum;
  logic [IDX_W+3:0] seg_wide;

  nfba_map #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .IDX_W      (IDX_W),
    .MAP_W      (MAP_W)
  ) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  nfba_need #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .CNT_W       (CNT_W)
  ) u_need (
    .clk   (clk),
    .load  (need_load),
    .bytes (in_data.request_bytes),
    .need  (need)
  );

  assign accept = start && (state_r == ST_IDLE);

  // free index: range check against the heap, then trim to an address
  assign fb_wide = {{IDX_W{1'b0}}, in_data.free_block};
  assign fb_ok   = fb_wide < (IDX_W + 4)'(NUM_BLOCKS);
  assign fb_idx  = fb_wide[IDX_W-1:0];

  assign bytes_ext = CHK_W'(in_data.request_bytes);
  assign size_bad  = (in_data.request_bytes == '0) || (bytes_ext > CHK_W'(HEAP_BYTES));

  // map entry decode; a positive entry is at most NUM_BLOCKS
  assign e_neg   = map_rdata[MAP_W-1];
  assign e_pos   = !e_neg && (map_rdata != '0);
  assign e_mag   = map_rdata[CNT_W-1:0];
  assign fits    = e_pos && (e_mag >= need);
  assign rest    = e_mag - need;
  assign end_sum = {1'b0, eval_r} + (IDX_W + 1)'(need);
  assign seg_wide = (IDX_W + 4)'(eval_r);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    eval_nxt      = eval_r;
    rdaddr_nxt    = rdaddr_r;
    cnt_nxt       = cnt_r;
    retry_nxt     = retry_r;
    rest_nxt      = rest_r;
    rest_addr_nxt = rest_addr_r;
    group_nxt     = group_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    skip_nxt      = skip_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    map_we        = 1'b0;
    map_waddr     = eval_r;
    map_wdata     = '0;
    map_re        = 1'b0;
    map_raddr     = rdaddr_r;
    need_load     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt.status        = STATUS_OK;
          out_data_nxt.segment_block = '0;
          if (in_data.command == CMD_FREE) begin
            if (fb_ok) begin
              map_re    = 1'b1;
              map_raddr = fb_idx;
              eval_nxt  = fb_idx;
              state_nxt = ST_FREE_CHECK;
            end else begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STATUS_FREE_BAD;
            end
          end else if (size_bad) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STATUS_ALLOC_FAIL;
          end else begin
            need_load = 1'b1;
            retry_nxt = 1'b0;
            state_nxt = ST_NEED;
          end
        end
      end

      ST_NEED: begin
        // block count was registered at accept
        state_nxt = ST_SCAN_START;
      end

      ST_SCAN_START: begin
        map_re     = 1'b1;
        map_raddr  = ptr_r;
        eval_nxt   = ptr_r;
        rdaddr_nxt = inc_idx(ptr_r);
        cnt_nxt    = '0;
        state_nxt  = ST_SCAN;
      end

      ST_SCAN: begin
        // read ahead one entry while checking the current one
        map_re     = 1'b1;
        map_raddr  = rdaddr_r;
        rdaddr_nxt = inc_idx(rdaddr_r);
        if (fits) begin
          map_we    = 1'b1;
          map_waddr = eval_r;
          map_wdata = '0 - {1'b0, need};
          ptr_nxt   = (end_sum == (IDX_W + 1)'(NUM_BLOCKS)) ? '0 : end_sum[IDX_W-1:0];
          if (rest != '0) begin
            rest_nxt      = rest;
            rest_addr_nxt = end_sum[IDX_W-1:0];
            state_nxt     = ST_WRITE_REST;
          end else begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.status        = STATUS_OK;
            out_data_nxt.segment_block = seg_wide[3:0];
            state_nxt                  = ST_IDLE;
          end
        end else begin
          eval_nxt = inc_idx(eval_r);
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(NUM_BLOCKS - 1)) begin
            if (coalesce_r && !retry_r) begin
              retry_nxt = 1'b1;
              state_nxt = ST_MERGE_START;
            end else begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STATUS_ALLOC_FAIL;
              state_nxt           = ST_IDLE;
            end
          end
        end
      end

      ST_WRITE_REST: begin
        map_we                     = 1'b1;
        map_waddr                  = rest_addr_r;
        map_wdata                  = {1'b0, rest_r};
        out_valid_nxt              = 1'b1;
        out_data_nxt.status        = STATUS_OK;
        out_data_nxt.segment_block = seg_wide[3:0];
        state_nxt                  = ST_IDLE;
      end

      ST_MERGE_START: begin
        map_re     = 1'b1;
        map_raddr  = '0;
        eval_nxt   = '0;
        rdaddr_nxt = IDX_W'(1);
        group_nxt  = 1'b0;
        skip_nxt   = '0;
        state_nxt  = ST_MERGE;
      end

      ST_MERGE: begin
        // linear walk: run interiors are skipped by count, free heads that
        // follow a free run are folded into the group head; no read-ahead
        // past the last entry, where it would wrap onto entry 0
        map_re     = (eval_r != IDX_W'(NUM_BLOCKS - 1));
        map_raddr  = rdaddr_r;
        rdaddr_nxt = inc_idx(rdaddr_r);
        eval_nxt   = inc_idx(eval_r);
        if (skip_r != '0) begin
          skip_nxt = skip_r - CNT_W'(1);
        end else if (e_pos) begin
          if (group_r) begin
            total_nxt = total_r + e_mag;
            map_we    = 1'b1;
            map_waddr = eval_r;
            map_wdata = '0;
          end else begin
            group_nxt = 1'b1;
            head_nxt  = eval_r;
            total_nxt = e_mag;
          end
          skip_nxt = e_mag - CNT_W'(1);
        end else if (group_r) begin
          map_we    = 1'b1;
          map_waddr = head_r;
          map_wdata = {1'b0, total_r};
          group_nxt = 1'b0;
        end
        if (eval_r == IDX_W'(NUM_BLOCKS - 1)) begin
          state_nxt = ST_MERGE_END;
        end
      end

      ST_MERGE_END: begin
        if (group_r) begin
          map_we    = 1'b1;
          map_waddr = head_r;
          map_wdata = {1'b0, total_r};
        end
        group_nxt = 1'b0;
        state_nxt = ST_SCAN_START;
      end

      ST_FREE_CHECK: begin
        out_valid_nxt = 1'b1;
        if (e_neg) begin
          map_we              = 1'b1;
          map_waddr           = eval_r;
          map_wdata           = '0 - map_rdata;
          out_data_nxt.status = STATUS_OK;
        end else begin
          out_data_nxt.status = STATUS_FREE_BAD;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      coalesce_r  <= 1'b1;
      retry_r     <= 1'b0;
      group_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      retry_r     <= retry_nxt;
      group_r     <= group_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        coalesce_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_r      <= eval_nxt;
    rdaddr_r    <= rdaddr_nxt;
    cnt_r       <= cnt_nxt;
    rest_r      <= rest_nxt;
    rest_addr_r <= rest_addr_nxt;
    head_r      <= head_nxt;
    total_r     <= total_nxt;
    skip_r      <= skip_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a result word only shows once the sequencer is back at rest
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result word while sequencer busy");

  // an accepted command either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command dropped");

  // read-ahead never targets the entry being written back
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (map_re && map_we) |-> (map_raddr != map_waddr))
    else $error("map read and write to the same entry");

  // the scan pointer moves only on a successful allocate
  a_ptr_moves_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(ptr_r) |-> ((state_r == ST_WRITE_REST) ||
                         (out_valid && (out_data.status == STATUS_OK))))
    else $error("scan pointer moved without an allocation");

  // nothing writes the map while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !map_we)
    else $error("map written while idle");

endmodule : next_fit_block_allocator

`default_nettype wire

@@ src/nfba_ram.sv @@
// ----------------------------------------------------------------------------
// nfba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : nfba_ram

`default_nettype wire

@@ src/nfba_map.sv @@
// ----------------------------------------------------------------------------
// nfba_map
// Block map store: RAM plus per-entry valid bits that stand in for the
// reset image (entry 0 holds the heap size, the rest zero).
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_map #(
  parameter int NUM_BLOCKS = 16,
  parameter int IDX_W      = 4,
  parameter int MAP_W      = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [MAP_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [MAP_W-1:0] rdata
);

  logic [NUM_BLOCKS-1:0] vld_r;
  logic                  vld_q_r;
  logic [IDX_W-1:0]      raddr_q_r;
  logic [MAP_W-1:0]      ram_q;
  logic [MAP_W-1:0]      rst_val;

  nfba_ram #(
    .WIDTH (MAP_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      vld_q_r   <= vld_r[raddr];
      raddr_q_r <= raddr;
    end
  end

  assign rst_val = (raddr_q_r == '0) ? MAP_W'(NUM_BLOCKS) : '0;
  assign rdata   = vld_q_r ? ram_q : rst_val;

endmodule : nfba_map

`default_nettype wire

@@ src/nfba_need.sv @@
// ----------------------------------------------------------------------------
// nfba_need
// Byte count to block count, rounded up, registered at load.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_need #(
  parameter int NUM_BLOCKS  = 16,
  parameter int BLOCK_BYTES = 64,
  parameter int CNT_W       = 5
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [15:0]      bytes,
  output logic      [CNT_W-1:0] need
);

  localparam int HEAP_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int HB_W       = $clog2(HEAP_BYTES + 1);
  localparam int ACC_W      = (HB_W > 17) ? HB_W : 17;

  logic [ACC_W-1:0] bytes_ext;
  logic [CNT_W-1:0] need_r, need_nxt;

  assign bytes_ext = ACC_W'(bytes);

  // smallest block count whose byte span covers the request; the request is
  // already known to be nonzero and within the heap
  always_comb begin
    need_nxt = CNT_W'(NUM_BLOCKS);
    for (int k = NUM_BLOCKS - 1; k >= 1; k--) begin
      if (bytes_ext <= ACC_W'(k * BLOCK_BYTES)) begin
        need_nxt = CNT_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      need_r <= need_nxt;
    end
  end

  assign need = need_r;

endmodule : nfba_need

`default_nettype wire
